### hdl/sfw_pkg.sv
// shared types and constants of the saturation fade weight block
// no dependencies; imported by every module of the block
package sfw_pkg;

    // input transaction payload
    typedef struct packed {
        logic        kind;
        logic [15:0] pixel;
        logic        pixel_valid;
    } t_in_item;

    // result transaction payload
    typedef struct packed {
        logic [16:0] weight;
        logic [11:0] column;
        logic [11:0] row;
        logic        frame_done;
    } t_out_item;

    // entry of the queue between front and back
    typedef struct packed {
        logic [15:0] max_val;
        logic [11:0] column;
        logic [11:0] row;
        logic        frame_done;
    } t_qentry;

    // write side of the queue
    typedef struct packed {
        logic    push;
        t_qentry data;
    } t_q_wr;

    // read side of the queue
    typedef struct packed {
        logic    empty;
        t_qentry data;
    } t_q_rd;

    typedef enum logic [1:0] {
        F_IDLE,
        F_UPD,
        F_EMIT_A,
        F_EMIT_B
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_DIV,
        B_SQ,
        B_MUL,
        B_OUT
    } t_back_state;

    // register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SAT_THRESH   = 2'd2;

    // input kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // weight arithmetic
    localparam logic [15:0] FADE_NUM   = 16'd55706;
    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [17:0] THREE_Q16  = 18'd196608;
    localparam int          DIV_STEPS  = 16;
    localparam int          QUEUE_DEPTH = 4;

endpackage

### hdl/saturation_fade_weight_3x3.sv
// path: a weight of 0 or 1.0 is registered on the result ports from the idle state; in the fade
// band the 16-step serial divider, square and multiply come first; a second result waits its turn
// flow: the front end takes no new transaction until it is through with the last one (row store
// read, update, up to two queue writes); the back end holds each weight until it is popped
// reset: synchronous active low; clears control state and the window, row stores not cleared
module saturation_fade_weight_3x3 #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  sfw_pkg::t_in_item  i_in_item,
    output logic               empty,
    input  logic               pop,
    output sfw_pkg::t_out_item o_out_item
);
    import sfw_pkg::*;

    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [15:0] r_sat_threshold;

    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full, q_pop;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= 13'd4096;
            r_frame_height  <= 13'd4096;
            r_sat_threshold <= 16'hFFFF;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                CFG_FRAME_WIDTH:  r_frame_width   <= pwdata[12:0];
                CFG_FRAME_HEIGHT: r_frame_height  <= pwdata[12:0];
                CFG_SAT_THRESH:   r_sat_threshold <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (paddr[3:2])
            CFG_FRAME_WIDTH:  prdata = {19'd0, r_frame_width};
            CFG_FRAME_HEIGHT: prdata = {19'd0, r_frame_height};
            CFG_SAT_THRESH:   prdata = {16'd0, r_sat_threshold};
            default:          prdata = '0;
        endcase
    end

    sfw_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_push         (push),
        .o_full         (full),
        .i_in_item      (i_in_item),
        .i_q_full       (q_full),
        .o_q_wr         (q_wr)
    );

    sfw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_rd    (q_rd)
    );

    sfw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sat_threshold (r_sat_threshold),
        .i_q_rd          (q_rd),
        .o_q_pop         (q_pop),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_out_item      (o_out_item)
    );

endmodule

### hdl/sfw_front.sv
// front end: position tracking, row stores, 3x3 window and maximum search
// depends on sfw_pkg; feeds sfw_queue
module sfw_front #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [12:0]       i_frame_width,
    input  logic [12:0]       i_frame_height,
    input  logic              i_push,
    output logic              o_full,
    input  sfw_pkg::t_in_item i_in_item,
    input  logic              i_q_full,
    output sfw_pkg::t_q_wr    o_q_wr
);
    import sfw_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    t_front_state r_state, n_state;

    logic [CW-1:0] r_in_col;
    logic [RW-1:0] r_in_row;
    logic [CW-1:0] r_c;
    logic [RW-1:0] r_r;
    t_in_item      r_item;
    logic [16:0]   r_win [9];
    logic [16:0]   r_up_q, r_mid_q;
    logic [16:0]   mem_up  [MAX_WIDTH];
    logic [16:0]   mem_mid [MAX_WIDTH];

    logic [WW-1:0] w;
    logic [RW-1:0] h;
    logic          accept;
    logic [CW-1:0] c_now;
    logic [RW-1:0] r_now;
    logic [16:0]   lower, up, mid;
    logic          last_col;
    logic          emit_a, emit_b;
    logic [15:0]   max_a, max_b;
    logic [2:0]    mask_a, mask_b;

    // effective frame size
    always_comb begin
        if (i_frame_width == 13'd0) begin
            w = WW'(1);
        end else if (15'(i_frame_width) > 15'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_frame_width);
        end
        if (i_frame_height == 13'd0) begin
            h = RW'(1);
        end else if (15'(i_frame_height) > 15'(MAX_HEIGHT)) begin
            h = RW'(MAX_HEIGHT);
        end else begin
            h = RW'(i_frame_height);
        end
    end

    // position of the incoming transaction, restarted if outside the frame
    always_comb begin
        if ((WW'(r_in_col) >= w) || (r_in_row > h)) begin
            c_now = '0;
            r_now = '0;
        end else begin
            c_now = r_in_col;
            r_now = r_in_row;
        end
    end

    assign accept   = i_push && !o_full;
    assign last_col = (WW'(r_c) == (w - WW'(1)));
    assign emit_a   = (r_r != '0) && (r_c != '0);
    assign emit_b   = (r_r != '0) && last_col;

    // window column values for the latched transaction
    always_comb begin
        lower = '0;
        if ((r_item.kind == KIND_PIXEL) && (r_r < h) && r_item.pixel_valid) begin
            lower = {1'b1, r_item.pixel};
        end
        up  = (r_r >= RW'(2)) ? r_up_q  : '0;
        mid = (r_r >= RW'(1)) ? r_mid_q : '0;
    end

    // masked maximum over window columns
    function automatic logic [15:0] win_max(input logic [16:0] win [9],
                                            input logic [2:0] mask);
        logic [15:0] best;
        best = '0;
        for (int i = 0; i < 9; i++) begin
            if (mask[i/3] && win[i][16] && (win[i][15:0] > best)) begin
                best = win[i][15:0];
            end
        end
        return best;
    endfunction

    assign mask_a = (r_c >= CW'(2)) ? 3'b111 : 3'b110;
    assign mask_b = (r_c >= CW'(1)) ? 3'b110 : 3'b100;
    assign max_a  = win_max(r_win, mask_a);
    assign max_b  = win_max(r_win, mask_b);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (accept) n_state = F_UPD;
            end
            F_UPD: begin
                if (emit_a) begin
                    n_state = F_EMIT_A;
                end else if (emit_b) begin
                    n_state = F_EMIT_B;
                end else begin
                    n_state = F_IDLE;
                end
            end
            F_EMIT_A: begin
                if (!i_q_full) n_state = emit_b ? F_EMIT_B : F_IDLE;
            end
            F_EMIT_B: begin
                if (!i_q_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_full      = (r_state != F_IDLE);
        o_q_wr.push = 1'b0;
        o_q_wr.data = '0;
        case (r_state)
            F_EMIT_A: begin
                o_q_wr.push            = !i_q_full;
                o_q_wr.data.max_val    = max_a;
                o_q_wr.data.column     = 12'(r_c - CW'(1));
                o_q_wr.data.row        = 12'(r_r - RW'(1));
                o_q_wr.data.frame_done = 1'b0;
            end
            F_EMIT_B: begin
                o_q_wr.push            = !i_q_full;
                o_q_wr.data.max_val    = max_b;
                o_q_wr.data.column     = 12'(r_c);
                o_q_wr.data.row        = 12'(r_r - RW'(1));
                o_q_wr.data.frame_done = (r_r == h);
            end
            default: ;
        endcase
    end

    // control registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_in_col <= '0;
            r_in_row <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                if ((WW'(c_now) + WW'(1)) >= w) begin
                    r_in_col <= '0;
                    r_in_row <= (r_now >= h) ? '0 : r_now + RW'(1);
                end else begin
                    r_in_col <= c_now + CW'(1);
                    r_in_row <= r_now;
                end
            end
        end
    end

    // window, reset to zero; the latched transaction below is not reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else if (r_state == F_UPD) begin
            for (int i = 0; i < 6; i++) r_win[i] <= r_win[i+3];
            r_win[6] <= up;
            r_win[7] <= mid;
            r_win[8] <= lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_c    <= c_now;
            r_r    <= r_now;
            r_item <= i_in_item;
        end
    end

    // row stores: read on accept, written during the update
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_up_q  <= mem_up[c_now];
            r_mid_q <= mem_mid[c_now];
        end
        if (r_state == F_UPD) begin
            mem_up[r_c]  <= r_mid_q;
            mem_mid[r_c] <= lower;
        end
    end

`ifndef SYNTHESIS
    a_accept_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == F_UPD))
        else $error("front: accepted transaction not followed by update");
    a_push_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_wr.push |-> ((r_state == F_EMIT_A) || (r_state == F_EMIT_B)))
        else $error("front: queue push outside emit states");
    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == F_UPD) |-> (WW'(r_c) < w))
        else $error("front: latched column outside frame");
`endif

endmodule

### hdl/sfw_queue.sv
// short register queue between front and back end
// depends on sfw_pkg
module sfw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sfw_pkg::t_q_wr i_wr,
    output logic           o_full,
    input  logic           i_pop,
    output sfw_pkg::t_q_rd o_rd
);
    import sfw_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_qentry      r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [PW:0]   r_count;
    logic          do_push, do_pop;

    assign o_full     = (r_count == (PW+1)'(QUEUE_DEPTH));
    assign o_rd.empty = (r_count == '0);
    assign o_rd.data  = r_mem[r_rd_ptr];
    assign do_push    = i_wr.push && !o_full;
    assign do_pop     = i_pop && !o_rd.empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + PW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + (PW+1)'(1);
                2'b01:   r_count <= r_count - (PW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_wr.data;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.push && o_full))
        else $error("queue: push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_rd.empty))
        else $error("queue: pop while empty");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue: fill count out of range");
`endif

endmodule

### hdl/sfw_back.sv
// back end: smoothstep weight from the window maximum, with a bit-serial divider
// depends on sfw_pkg; reads sfw_queue
module sfw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [15:0]        i_sat_threshold,
    input  sfw_pkg::t_q_rd     i_q_rd,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output sfw_pkg::t_out_item o_out_item
);
    import sfw_pkg::*;

    t_back_state r_state, n_state;

    logic [15:0] r_fade;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [15:0] r_quot;
    logic [3:0]  r_step;
    logic [31:0] r_sq;
    logic [17:0] r_t;
    logic [16:0] r_weight;
    logic [11:0] r_col, r_row;
    logic        r_done;

    logic        take;
    logic        fade_case;
    logic [31:0] fade_prod;
    logic [17:0] rem_sh;
    logic        sub_ok;
    logic [49:0] prod;
    logic [15:0] m;

    assign m         = i_q_rd.data.max_val;
    assign take      = (r_state == B_IDLE) && !i_q_rd.empty;
    assign fade_case = (i_sat_threshold != '0) && (m > r_fade) && (m < i_sat_threshold);
    assign fade_prod = 32'(i_sat_threshold) * 32'(FADE_NUM);
    assign rem_sh    = {r_rem, 1'b0};
    assign sub_ok    = (rem_sh >= 18'(r_den));
    assign prod      = 50'(r_sq) * 50'(r_t);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (take) n_state = fade_case ? B_DIV : B_OUT;
            end
            B_DIV: begin
                if (r_step == 4'(DIV_STEPS - 1)) n_state = B_SQ;
            end
            B_SQ:  n_state = B_MUL;
            B_MUL: n_state = B_OUT;
            B_OUT: begin
                if (i_pop) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop               = take;
        o_empty               = (r_state != B_OUT);
        o_out_item.weight     = r_weight;
        o_out_item.column     = r_col;
        o_out_item.row        = r_row;
        o_out_item.frame_done = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // fade start follows the threshold register
    always_ff @(posedge i_clk) begin
        r_fade <= fade_prod[31:16];
    end

    // weight datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (take) begin
                    r_col  <= i_q_rd.data.column;
                    r_row  <= i_q_rd.data.row;
                    r_done <= i_q_rd.data.frame_done;
                    r_rem  <= 17'(i_sat_threshold - m);
                    r_den  <= i_sat_threshold - r_fade;
                    r_quot <= '0;
                    r_step <= '0;
                    if ((i_sat_threshold == '0) || (m >= i_sat_threshold)) begin
                        r_weight <= '0;
                    end else begin
                        r_weight <= ONE_Q16;
                    end
                end
            end
            // one quotient bit a cycle
            B_DIV: begin
                r_rem  <= sub_ok ? 17'(rem_sh - 18'(r_den)) : rem_sh[16:0];
                r_quot <= {r_quot[14:0], sub_ok};
                r_step <= r_step + 4'd1;
            end
            B_SQ: begin
                r_sq <= 32'(r_quot) * 32'(r_quot);
                r_t  <= THREE_Q16 - {1'b0, r_quot, 1'b0};
            end
            B_MUL: begin
                r_weight <= prod[48:32];
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pop && !o_empty) |=> (r_state == B_IDLE))
        else $error("back: result transaction not retired");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_den != '0))
        else $error("back: zero divisor");
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (r_weight <= ONE_Q16))
        else $error("back: weight above one");
`endif

endmodule
